// ===== hw/rtl/rekq_pkg.sv =====
// Package with the shared types, codes and the quadrature transition table.
`timescale 1ns / 1ps

package rekq_pkg;

    typedef logic [3:0]         action_t;
    typedef logic signed [15:0] pulse_t;
    typedef logic signed [14:0] steps_t;
    typedef logic signed [2:0]  carry_t;
    typedef logic signed [1:0]  delta_t;

    localparam action_t ACTION_NONE   = 4'd0;
    localparam action_t ACTION_SELECT = 4'd8;

    localparam logic [3:0] HISTORY_RESET = 4'b0011;
    localparam logic [3:0] HISTORY_MASK  = 4'hF;

    localparam int PULSES_PER_DETENT = 4;

    localparam pulse_t PULSE_MAX = 16'sh7FFF;
    localparam pulse_t PULSE_MIN = -16'sh8000;

    localparam steps_t STEPS_MAX = 15'sd8192;
    localparam steps_t STEPS_MIN = -15'sd8192;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

    // Quadrature transition table, indexed by {old A, old B, new A, new B}.
    function automatic delta_t step_delta(input logic [3:0] hist);
        delta_t d;
        begin
            case (hist)
                4'h1, 4'h7, 4'h8, 4'hE: d = -2'sd1;
                4'h2, 4'h4, 4'hB, 4'hD: d = 2'sd1;
                default:                d = 2'sd0;
            endcase
            return d;
        end
    endfunction

endpackage

// ===== hw/rtl/rekq_if.sv =====
// Channel interfaces for poll and encoder requests, results and configuration.
`timescale 1ns / 1ps

interface rekq_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        enc_a;
    logic        enc_b;
    logic [2:0]  bus_pins;
    logic        sel_pin;
    logic        mode_pin;
    logic [31:0] now_ms;

    modport source (output valid, func, enc_a, enc_b, bus_pins, sel_pin, mode_pin,
                    now_ms, input ready);
    modport sink   (input valid, func, enc_a, enc_b, bus_pins, sel_pin, mode_pin,
                    now_ms, output ready);
endinterface

interface rekq_out_if;
    logic                 valid;
    logic                 ready;
    rekq_pkg::action_t    action;
    rekq_pkg::steps_t     rotation_steps;
    logic                 display_mode;

    modport source (output valid, action, rotation_steps, display_mode, input ready);
    modport sink   (input valid, action, rotation_steps, display_mode, output ready);
endinterface

interface rekq_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] debounce_ms;

    modport source (output valid, debounce_ms, input ready);
    modport sink   (input valid, debounce_ms, output ready);
endinterface

// ===== hw/rtl/rotary_encoder_keypad_qualifier.sv =====
// Top level of the rotary encoder and key pad qualifier.
`timescale 1ns / 1ps

// The block takes one request per clock cycle on the item channel while no poll waits.
// An encoder request (func 0) updates the quadrature history and the saturating
// pulse count and produces no result; a poll request (func 1) debounces the
// select pin and the key bus against now_ms and produces exactly one result.
// Each request is first captured in an input register; from there the update
// logic writes the block state and, for a poll, the result register, which
// offers the result on the result channel until the sink takes it.
// The result register is the only place where a poll can wait: item.ready drops
// only while a poll sits in the input register and the result register still
// holds a result that the sink has not taken. Encoder requests never wait.
// The debounce time is written on the cfg channel, which is always ready; write
// it only while no request is in flight. It resets to 50 ms, and an input must
// stay unchanged for strictly longer than that before its debounced level follows.
module rotary_encoder_keypad_qualifier (
    input  logic       clk,
    input  logic       rst_n,
    rekq_in_if.sink    item,
    rekq_out_if.source result,
    rekq_cfg_if.sink   cfg
);

    // Configuration register.
    logic [15:0] debounce_ms_reg;

    // Input register stage.
    logic        s1_valid_reg;
    logic        s1_func_reg;
    logic [1:0]  s1_ab_reg;
    logic [2:0]  s1_bus_reg;
    logic        s1_sel_reg;
    logic        s1_mode_reg;
    logic [31:0] s1_now_reg;

    // Block state.
    logic [3:0]        history_reg,      history_next;
    rekq_pkg::pulse_t  pulse_reg,        pulse_next;
    rekq_pkg::carry_t  carry_reg,        carry_next;
    logic [2:0]        bus_last_reg,     bus_last_next;
    logic [2:0]        bus_stable_reg,   bus_stable_next;
    logic [31:0]       bus_time_reg,     bus_time_next;
    logic              sel_last_reg,     sel_last_next;
    logic              sel_stable_reg,   sel_stable_next;
    logic [31:0]       sel_time_reg,     sel_time_next;
    rekq_pkg::action_t prev_action_reg,  prev_action_next;

    // Result register.
    logic              out_valid_reg;
    rekq_pkg::action_t out_action_reg,   out_action_next;
    rekq_pkg::steps_t  out_steps_reg,    out_steps_next;
    logic              out_mode_reg;

    logic s1_advance;
    logic s1_poll_done;
    logic item_take;

    // A captured encoder request always retires; a poll retires when the result
    // register is empty or being emptied in this cycle.
    assign s1_advance   = s1_valid_reg &&
                          (!s1_func_reg || !out_valid_reg || result.ready);
    assign s1_poll_done = s1_advance && s1_func_reg;
    assign item.ready   = !s1_valid_reg || s1_advance;
    assign item_take    = item.valid && item.ready;

    assign cfg.ready = 1'b1;

    assign result.valid          = out_valid_reg;
    assign result.action         = out_action_reg;
    assign result.rotation_steps = out_steps_reg;
    assign result.display_mode   = out_mode_reg;

    // Update logic for one captured request.
    logic [3:0]                hist_new;
    logic signed [16:0]        pulse_sum;
    logic [2:0]                bus_act;
    logic                      sel_stable_v;
    rekq_pkg::action_t         act_raw;
    logic signed [15:0]        q_floor;
    logic signed [15:0]        q_trunc;
    logic signed [15:0]        rem_full;
    logic signed [3:0]         carry_sum;
    rekq_pkg::steps_t          steps_raw;

    always_comb
    begin
        history_next     = history_reg;
        pulse_next       = pulse_reg;
        carry_next       = carry_reg;
        bus_last_next    = bus_last_reg;
        bus_stable_next  = bus_stable_reg;
        bus_time_next    = bus_time_reg;
        sel_last_next    = sel_last_reg;
        sel_stable_next  = sel_stable_reg;
        sel_time_next    = sel_time_reg;
        prev_action_next = prev_action_reg;
        out_action_next  = rekq_pkg::ACTION_NONE;
        out_steps_next   = '0;

        hist_new  = ((history_reg << 2) | {2'b00, s1_ab_reg}) & rekq_pkg::HISTORY_MASK;
        pulse_sum = 17'(pulse_reg) + 17'(rekq_pkg::step_delta(hist_new));

        bus_act      = ~s1_bus_reg;
        sel_stable_v = sel_stable_reg;
        act_raw      = rekq_pkg::ACTION_NONE;

        // Truncating division of the pulse count by four, remainder carries sign.
        q_floor   = pulse_reg >>> 2;
        q_trunc   = q_floor + 16'((pulse_reg[15] && (pulse_reg[1:0] != 2'b00)) ? 1 : 0);
        rem_full  = pulse_reg - (q_trunc <<< 2);
        carry_sum = 4'(carry_reg) + 4'(signed'(rem_full[2:0]));
        steps_raw = q_trunc[14:0];

        if (s1_advance)
        begin
            if (!s1_func_reg)
            begin
                history_next = hist_new;
                if (pulse_sum > 17'(rekq_pkg::PULSE_MAX))
                    pulse_next = rekq_pkg::PULSE_MAX;
                else if (pulse_sum < 17'(rekq_pkg::PULSE_MIN))
                    pulse_next = rekq_pkg::PULSE_MIN;
                else
                    pulse_next = pulse_sum[15:0];
            end
            else
            begin
                // Select debouncer runs on every poll.
                if (s1_sel_reg != sel_last_reg)
                    sel_time_next = s1_now_reg;
                if ((s1_now_reg - sel_time_next) > {16'd0, debounce_ms_reg})
                    sel_stable_v = s1_sel_reg;
                sel_stable_next = sel_stable_v;
                sel_last_next   = s1_sel_reg;

                if (!sel_stable_v)
                begin
                    act_raw = rekq_pkg::ACTION_SELECT;
                end
                else
                begin
                    // The bus debouncer only moves while select is released.
                    if (bus_act != bus_last_reg)
                        bus_time_next = s1_now_reg;
                    if ((s1_now_reg - bus_time_next) > {16'd0, debounce_ms_reg})
                        bus_stable_next = bus_act;
                    bus_last_next = bus_act;
                    act_raw = {1'b0, bus_stable_next};
                end

                pulse_next = '0;
                if (act_raw != rekq_pkg::ACTION_NONE)
                begin
                    // A repeated action reads as none but still drops the pulses.
                    if (prev_action_reg != act_raw)
                    begin
                        out_action_next  = act_raw;
                        prev_action_next = act_raw;
                    end
                end
                else
                begin
                    if (carry_sum >= 4'sd4)
                    begin
                        steps_raw  = steps_raw + 15'sd1;
                        carry_next = 3'(carry_sum - 4'sd4);
                    end
                    else if (carry_sum <= -4'sd4)
                    begin
                        steps_raw  = steps_raw - 15'sd1;
                        carry_next = 3'(carry_sum + 4'sd4);
                    end
                    else
                    begin
                        carry_next = carry_sum[2:0];
                    end
                    if (steps_raw > rekq_pkg::STEPS_MAX)
                        out_steps_next = rekq_pkg::STEPS_MAX;
                    else if (steps_raw < rekq_pkg::STEPS_MIN)
                        out_steps_next = rekq_pkg::STEPS_MIN;
                    else
                        out_steps_next = steps_raw;
                    prev_action_next = rekq_pkg::ACTION_NONE;
                end
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= rekq_pkg::DEBOUNCE_RESET;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            history_reg     <= rekq_pkg::HISTORY_RESET;
            pulse_reg       <= '0;
            carry_reg       <= '0;
            bus_last_reg    <= '0;
            bus_stable_reg  <= '0;
            bus_time_reg    <= '0;
            sel_last_reg    <= 1'b1;
            sel_stable_reg  <= 1'b1;
            sel_time_reg    <= '0;
            prev_action_reg <= rekq_pkg::ACTION_NONE;
        end
        else
        begin
            if (cfg.valid)
                debounce_ms_reg <= cfg.debounce_ms;

            if (item_take)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (s1_poll_done)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            history_reg     <= history_next;
            pulse_reg       <= pulse_next;
            carry_reg       <= carry_next;
            bus_last_reg    <= bus_last_next;
            bus_stable_reg  <= bus_stable_next;
            bus_time_reg    <= bus_time_next;
            sel_last_reg    <= sel_last_next;
            sel_stable_reg  <= sel_stable_next;
            sel_time_reg    <= sel_time_next;
            prev_action_reg <= prev_action_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_func_reg <= item.func;
            s1_ab_reg   <= {item.enc_a, item.enc_b};
            s1_bus_reg  <= item.bus_pins;
            s1_sel_reg  <= item.sel_pin;
            s1_mode_reg <= item.mode_pin;
            s1_now_reg  <= item.now_ms;
        end
        if (s1_poll_done)
        begin
            out_action_reg <= out_action_next;
            out_steps_reg  <= out_steps_next;
            out_mode_reg   <= !s1_mode_reg;
        end
    end

endmodule

// ===== tb/tb_rotary_encoder_keypad_qualifier.sv =====
// Self-checking testbench for the rotary encoder and key pad qualifier.
`timescale 1ns / 1ps

// The testbench sends encoder and poll requests on the item channel and sets the
// debounce time on the cfg channel. A model of the block, kept in this file,
// runs on every accepted request and queues the result that each poll must
// produce. A monitor takes each result from the result channel and checks it,
// field by field, against the oldest queued result.
//
// The run is split into phases, one for each debounce setting. Between phases
// the testbench waits until every queued result has arrived and the pipeline
// has drained, and only then writes the register. The phases are:
//   - a short directed part at the reset value of 50 ms,
//   - random traffic at 0 ms and at 65535 ms,
//   - random traffic at a random debounce time,
//   - a final random part in which neither side inserts idle cycles.
module tb_rotary_encoder_keypad_qualifier;

    localparam int CYCLE_LIMIT = 2_000_000;

    // Pulse value of each {old A, old B, new A, new B} transition.
    localparam int QUAD_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

    typedef struct {
        logic        func;
        logic        enc_a;
        logic        enc_b;
        logic [2:0]  bus_pins;
        logic        sel_pin;
        logic        mode_pin;
        logic [31:0] now_ms;
    } pin_request_t;

    typedef struct {
        rekq_pkg::action_t action;
        rekq_pkg::steps_t  steps;
        logic              display_mode;
    } poll_report_t;

    logic clk;
    logic rst_n;

    rekq_in_if  item_if ();
    rekq_out_if result_if ();
    rekq_cfg_if cfg_if ();

    rotary_encoder_keypad_qualifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always #4 clk = ~clk;

    // Requests waiting to be driven, and the results that accepted polls must give.
    pin_request_t pin_requests [$];
    poll_report_t expected_reports [$];

    pin_request_t cur_req;
    poll_report_t new_report;
    poll_report_t oldest;
    bit           holding;
    bit           idle_en;
    int           queued_items;
    int           mismatch_count;
    int           cycle_count;
    int           src_gap;
    int           src_calm;
    int           snk_gap;
    int           snk_calm;

    // Generator side: where the encoder pins and the clock in ms stand as the
    // requests are queued, and the debounce time of the current phase.
    logic [1:0]   gen_ab;
    logic [31:0]  gen_now;
    int           gen_dbc;

    // Model state of the block.
    logic [15:0]        debounce_now;
    logic [3:0]         hist;
    rekq_pkg::pulse_t   pulses;
    int                 carry;
    logic [2:0]         key_raw;
    logic [2:0]         key_level;
    logic [31:0]        key_since;
    logic               sel_raw;
    logic               sel_level;
    logic [31:0]        sel_since;
    rekq_pkg::action_t  last_action;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Runs one request through the model. Returns 1 when the request is a poll,
    // and then rpt holds the result that the block must produce for it.
    function automatic bit qualify_request(input pin_request_t rq, output poll_report_t rpt);
        int                 p;
        int                 raw;
        int                 steps;
        logic [2:0]         keys;
        logic [31:0]        elapsed;
        rekq_pkg::action_t  act;
        rpt = '{rekq_pkg::ACTION_NONE, '0, 1'b0};
        if (!rq.func)
        begin
            hist = {hist[1:0], rq.enc_a, rq.enc_b};
            p = int'(pulses) + QUAD_STEP[hist];
            if (p > 32767)
                p = 32767;
            if (p < -32768)
                p = -32768;
            pulses = rekq_pkg::pulse_t'(p);
            return 1'b0;
        end

        // The select pin is debounced on every poll.
        if (rq.sel_pin != sel_raw)
            sel_since = rq.now_ms;
        elapsed = rq.now_ms - sel_since;
        if (elapsed > {16'd0, debounce_now})
            sel_level = rq.sel_pin;
        sel_raw = rq.sel_pin;

        // The key bus is debounced only while select is released.
        if (sel_level == 1'b0)
        begin
            act = rekq_pkg::ACTION_SELECT;
        end
        else
        begin
            keys = ~rq.bus_pins;
            if (keys != key_raw)
                key_since = rq.now_ms;
            elapsed = rq.now_ms - key_since;
            if (elapsed > {16'd0, debounce_now})
                key_level = keys;
            key_raw = keys;
            act = {1'b0, key_level};
        end

        steps = 0;
        if (act != rekq_pkg::ACTION_NONE)
        begin
            // Any action drops the rotation seen so far; a repeat reads as none.
            pulses = '0;
            if (last_action == act)
                act = rekq_pkg::ACTION_NONE;
            else
                last_action = act;
        end
        else
        begin
            // Truncating division; the remainder builds up in the carry.
            raw = int'(pulses);
            pulses = '0;
            steps = raw / rekq_pkg::PULSES_PER_DETENT;
            carry += raw % rekq_pkg::PULSES_PER_DETENT;
            if (carry >= rekq_pkg::PULSES_PER_DETENT || carry <= -rekq_pkg::PULSES_PER_DETENT)
            begin
                steps += carry / rekq_pkg::PULSES_PER_DETENT;
                carry = carry % rekq_pkg::PULSES_PER_DETENT;
            end
            if (steps > 8192)
                steps = 8192;
            if (steps < -8192)
                steps = -8192;
            last_action = rekq_pkg::ACTION_NONE;
        end
        rpt.action = act;
        rpt.steps = rekq_pkg::steps_t'(steps);
        rpt.display_mode = ~rq.mode_pin;
        return 1'b1;
    endfunction

    // Next pin pair one detent quarter forward or backward.
    function automatic logic [1:0] fwd_ab(input logic [1:0] ab);
        case (ab)
            2'b00:   return 2'b10;
            2'b10:   return 2'b11;
            2'b11:   return 2'b01;
            default: return 2'b00;
        endcase
    endfunction

    function automatic logic [1:0] bwd_ab(input logic [1:0] ab);
        case (ab)
            2'b00:   return 2'b01;
            2'b01:   return 2'b11;
            2'b11:   return 2'b10;
            default: return 2'b00;
        endcase
    endfunction

    task automatic push_request(input pin_request_t rq);
        pin_requests.push_back(rq);
        queued_items++;
    endtask

    // Encoder request; the poll fields carry random values that the block ignores.
    task automatic push_enc(input logic [1:0] ab);
        pin_request_t rq;
        rq.func = 1'b0;
        rq.enc_a = ab[1];
        rq.enc_b = ab[0];
        rq.bus_pins = 3'($urandom_range(0, 7));
        rq.sel_pin = 1'($urandom_range(0, 1));
        rq.mode_pin = 1'($urandom_range(0, 1));
        rq.now_ms = $urandom();
        gen_ab = ab;
        push_request(rq);
    endtask

    task automatic push_poll(input logic [2:0] pins, input logic sel, input logic mode,
                             input logic [31:0] now);
        pin_request_t rq;
        rq.func = 1'b1;
        rq.enc_a = 1'($urandom_range(0, 1));
        rq.enc_b = 1'($urandom_range(0, 1));
        rq.bus_pins = pins;
        rq.sel_pin = sel;
        rq.mode_pin = mode;
        rq.now_ms = now;
        gen_now = now;
        push_request(rq);
    endtask

    task automatic poll_after(input logic [2:0] pins, input logic sel, input logic [31:0] adv);
        push_poll(pins, sel, 1'($urandom_range(0, 1)), gen_now + adv);
    endtask

    // Time step to the next poll: within the debounce window, or at or past its end.
    function automatic logic [31:0] pick_adv(input bit long_gap);
        if (!long_gap)
            return $urandom_range(0, gen_dbc);
        case ($urandom_range(0, 3))
            0:       return gen_dbc;
            1:       return gen_dbc + 1;
            default: return gen_dbc + 1 + $urandom_range(0, 2 * gen_dbc + 8);
        endcase
    endfunction

    // A key or select press: some chatter, a hold that may or may not outlast
    // the debounce time, maybe some rotation meanwhile, then a release.
    task automatic press_sequence();
        bit         use_sel;
        logic [2:0] pins;
        logic       sel;
        use_sel = ($urandom_range(0, 3) == 0);
        pins = use_sel ? 3'($urandom_range(0, 7)) : ~3'($urandom_range(1, 7));
        sel = ~use_sel;
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 1))
                poll_after(pins, sel, pick_adv(1'b0));
            else
                poll_after(3'b111, 1'b1, pick_adv(1'b0));
        end
        repeat ($urandom_range(1, 4))
        begin
            poll_after(pins, sel, pick_adv($urandom_range(0, 2) != 0));
            if ($urandom_range(0, 3) == 0)
                push_enc(fwd_ab(gen_ab));
        end
        repeat ($urandom_range(1, 3))
            poll_after(3'b111, 1'b1, pick_adv($urandom_range(0, 2) != 0));
    endtask

    task automatic run_random(input int n_items);
        int           start;
        int           pick;
        bit           dirn;
        pin_request_t rq;
        start = queued_items;
        while (queued_items - start < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // Encoder walk, with the odd step back as contact bounce.
                dirn = 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 14))
                begin
                    if (($urandom_range(0, 9) == 0) ^ dirn)
                        push_enc(bwd_ab(gen_ab));
                    else
                        push_enc(fwd_ab(gen_ab));
                end
                if ($urandom_range(0, 1))
                    poll_after(3'b111, 1'b1, pick_adv(1'b0));
            end
            else if (pick < 70)
            begin
                press_sequence();
            end
            else if (pick < 88)
            begin
                poll_after(3'b111, 1'b1, pick_adv($urandom_range(0, 1)));
            end
            else if (pick < 95)
            begin
                // Move the clock close to its wrap point.
                gen_now = 32'hFFFF_FFFF - $urandom_range(0, 3 * gen_dbc + 10);
            end
            else
            begin
                // Noise: any request at all, at any time.
                rq.func = 1'($urandom_range(0, 1));
                rq.enc_a = 1'($urandom_range(0, 1));
                rq.enc_b = 1'($urandom_range(0, 1));
                rq.bus_pins = 3'($urandom_range(0, 7));
                rq.sel_pin = 1'($urandom_range(0, 1));
                rq.mode_pin = 1'($urandom_range(0, 1));
                rq.now_ms = $urandom();
                if (rq.func)
                    gen_now = rq.now_ms;
                else
                    gen_ab = {rq.enc_a, rq.enc_b};
                push_request(rq);
            end
        end
    endtask

    // Waits until every request is in, every result is out, and the pipeline
    // has had time to finish a trailing encoder request.
    task automatic wait_idle();
        while (pin_requests.size() != 0 || holding || expected_reports.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_debounce(input logic [15:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.debounce_ms <= val;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        gen_dbc = int'(val);
    endtask

    // Request driver. A request stays on the channel until it is accepted; new
    // requests or idle bursts are set up at the falling edge only.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (src_calm > 0)
                src_calm--;
            else if ($urandom_range(0, 63) == 0)
                src_calm = $urandom_range(16, 64);
            if (!holding)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    item_if.valid <= 1'b0;
                end
                else if (idle_en && src_calm == 0 && $urandom_range(0, 5) == 0)
                begin
                    // This cycle opens a burst of idle cycles; src_gap holds the ones that follow it.
                    src_gap = $urandom_range(0, 6);
                    item_if.valid <= 1'b0;
                end
                else if (pin_requests.size() != 0)
                begin
                    cur_req = pin_requests.pop_front();
                    holding = 1'b1;
                    item_if.valid <= 1'b1;
                    item_if.func <= cur_req.func;
                    item_if.enc_a <= cur_req.enc_a;
                    item_if.enc_b <= cur_req.enc_b;
                    item_if.bus_pins <= cur_req.bus_pins;
                    item_if.sel_pin <= cur_req.sel_pin;
                    item_if.mode_pin <= cur_req.mode_pin;
                    item_if.now_ms <= cur_req.now_ms;
                end
                else
                begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink stalls in bursts of the same kind.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (snk_calm > 0)
                snk_calm--;
            else if ($urandom_range(0, 63) == 0)
                snk_calm = $urandom_range(16, 64);
            if (snk_gap > 0)
            begin
                snk_gap--;
                result_if.ready <= 1'b0;
            end
            else if (idle_en && snk_calm == 0 && $urandom_range(0, 5) == 0)
            begin
                snk_gap = $urandom_range(0, 6);
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // The model follows every register write and every accepted request.
    always @(posedge clk)
    begin
        if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
            debounce_now = cfg_if.debounce_ms;
        if (item_if.valid === 1'b1 && item_if.ready === 1'b1 && holding)
        begin
            if (qualify_request(cur_req, new_report))
                expected_reports.push_back(new_report);
            holding = 1'b0;
        end
    end

    // Monitor: each result taken by the sink is checked against the oldest poll.
    always @(posedge clk)
    begin
        if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (expected_reports.size() == 0)
            begin
                report_mismatch("result arrived with no poll outstanding");
            end
            else
            begin
                oldest = expected_reports.pop_front();
                if (result_if.action !== oldest.action)
                    report_mismatch($sformatf("action got %0d expected %0d",
                                              result_if.action, oldest.action));
                if (result_if.rotation_steps !== oldest.steps)
                    report_mismatch($sformatf("rotation_steps got %0d expected %0d",
                                              result_if.rotation_steps, oldest.steps));
                if (result_if.display_mode !== oldest.display_mode)
                    report_mismatch($sformatf("display_mode got %0b expected %0b",
                                              result_if.display_mode, oldest.display_mode));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.func = 1'b0;
        item_if.enc_a = 1'b0;
        item_if.enc_b = 1'b0;
        item_if.bus_pins = 3'b111;
        item_if.sel_pin = 1'b1;
        item_if.mode_pin = 1'b1;
        item_if.now_ms = '0;
        result_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.debounce_ms = '0;
        holding = 1'b0;
        idle_en = 1'b1;
        queued_items = 0;
        mismatch_count = 0;
        cycle_count = 0;
        src_gap = 0;
        src_calm = 0;
        snk_gap = 0;
        snk_calm = 0;

        // Model at its reset state.
        debounce_now = rekq_pkg::DEBOUNCE_RESET;
        hist = rekq_pkg::HISTORY_RESET;
        pulses = '0;
        carry = 0;
        key_raw = '0;
        key_level = '0;
        key_since = '0;
        sel_raw = 1'b1;
        sel_level = 1'b1;
        sel_since = '0;
        last_action = rekq_pkg::ACTION_NONE;

        gen_ab = 2'b11;
        gen_now = '0;
        gen_dbc = int'(rekq_pkg::DEBOUNCE_RESET);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, at the reset debounce time of 50 ms.
        push_poll(3'b111, 1'b1, 1'b1, 32'd0);
        repeat (4) push_enc(fwd_ab(gen_ab));
        push_enc(bwd_ab(gen_ab));
        push_poll(3'b111, 1'b1, 1'b0, 32'd10);
        repeat (2) push_enc(fwd_ab(gen_ab));
        // Both pins change at once, which the table counts as no movement.
        push_enc(~gen_ab);
        // The carried remainder reaches a full detent here.
        push_poll(3'b111, 1'b1, 1'b1, 32'd20);
        push_poll(3'b110, 1'b1, 1'b1, 32'd100);
        // Held for exactly the debounce time: not yet taken.
        push_poll(3'b110, 1'b1, 1'b1, 32'd150);
        push_poll(3'b110, 1'b1, 1'b1, 32'd151);
        // The same key again is suppressed, and the rotation in between dropped.
        push_poll(3'b110, 1'b1, 1'b1, 32'd160);
        push_enc(fwd_ab(gen_ab));
        push_poll(3'b110, 1'b1, 1'b1, 32'd170);
        // Select outranks any key.
        push_poll(3'b110, 1'b0, 1'b1, 32'd200);
        push_poll(3'b110, 1'b0, 1'b1, 32'd251);
        push_poll(3'b000, 1'b0, 1'b0, 32'd260);
        push_poll(3'b111, 1'b1, 1'b1, 32'd300);
        push_poll(3'b111, 1'b1, 1'b1, 32'd400);
        // All keys pressed across the wrap of the ms clock.
        push_poll(3'b000, 1'b1, 1'b1, 32'hFFFF_FFE0);
        push_poll(3'b000, 1'b1, 1'b0, 32'h0000_0013);
        push_poll(3'b111, 1'b1, 1'b1, 32'h0000_0100);
        push_poll(3'b111, 1'b1, 1'b1, 32'h0000_0200);
        wait_idle();

        write_debounce(16'd0);
        run_random(100);
        wait_idle();

        write_debounce(16'hFFFF);
        run_random(100);
        wait_idle();

        write_debounce(16'($urandom_range(1, 300)));
        run_random(150);
        wait_idle();

        // Last part: both sides run without idle cycles.
        write_debounce(16'($urandom_range(2, 120)));
        idle_en = 1'b0;
        run_random(150);
        wait_idle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== rotary_encoder_keypad_qualifier.f =====
hw/rtl/rekq_pkg.sv
hw/rtl/rekq_if.sv
hw/rtl/rotary_encoder_keypad_qualifier.sv
tb/tb_rotary_encoder_keypad_qualifier.sv
